// File: rtl/injective_mapping_enumerator_macros.svh
// Assertion macros for the mapping enumerator
`ifndef INJECTIVE_MAPPING_ENUMERATOR_MACROS_SVH
`define INJECTIVE_MAPPING_ENUMERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define IME_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define IME_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define IME_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define IME_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: rtl/ime_pkg.sv
package ime_pkg;
    localparam int MAX_ELEMS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int SIZE_BITS      = 5;
    localparam int SLOT_BITS      = 4;
    localparam int OP_BITS        = 2;
    localparam int CFG_IDX_BITS   = 1;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_NEXT   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_A = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_B = 1'b1;
endpackage

// File: rtl/ime_elem_store.sv
// Two element memories, one write and one registered read each.
module ime_elem_store #(
    parameter int MAX_ELEMS  = 16,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 4
) (
    input  logic                  clk,
    input  logic                  wr_a,
    input  logic                  wr_b,
    input  logic [AW-1:0]         wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [AW-1:0]         rd_a_addr,
    input  logic [AW-1:0]         rd_b_addr,
    output logic [VALUE_BITS-1:0] rd_a_data,
    output logic [VALUE_BITS-1:0] rd_b_data
);
    logic [VALUE_BITS-1:0] mem_a [MAX_ELEMS];
    logic [VALUE_BITS-1:0] mem_b [MAX_ELEMS];

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_a_data <= mem_a[rd_a_addr];
        rd_b_data <= mem_b[rd_b_addr];
    end
endmodule

// File: rtl/injective_mapping_enumerator.sv
// Flow: a load is written at the accepting edge. A next item first walks to its
// successor, backing over (S_BACK), scanning (S_SCAN) and refilling (S_FILL) every
// position it must, one B index per cycle, then S_EMIT sends its pairs; a done item
// strobes in the cycle after it is taken, or after the walk when it finds nothing.
// Throughput: one item at a time, pairs one per cycle; busy drops while the last
// pair is on the ports. Reset: async, sizes go to 1; element memories not reset.
`include "injective_mapping_enumerator_macros.svh"
module injective_mapping_enumerator #(
    parameter int MAX_ELEMS  = ime_pkg::MAX_ELEMS_DEF,
    parameter int VALUE_BITS = ime_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ime_pkg::OP_BITS-1:0]  op,
    input  logic [ime_pkg::SLOT_BITS-1:0] slot,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ime_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ime_pkg::SIZE_BITS-1:0] cfg_data,
    output logic                         strobe,
    output logic signed [VALUE_BITS-1:0] a_value,
    output logic signed [VALUE_BITS-1:0] b_value,
    output logic                         last,
    output logic                         done_res
);
    import ime_pkg::*;

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_BACK, S_SCAN, S_FILL, S_EMIT, S_DONE
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         size_a_reg, size_b_reg;
    logic [AW-1:0]         chosen_reg [MAX_ELEMS];  // small index memory
    logic [MAX_ELEMS-1:0]  used_reg;
    logic                  started_reg, exhausted_reg;
    logic [CW-1:0]         pos_reg;   // position being worked on
    logic [CW-1:0]         cand_reg;  // candidate B index
    logic [CW-1:0]         na, nb;
    logic                  emit_v_reg;
    logic                  emit_last_reg;
    logic [AW-1:0]         rd_a_addr, rd_b_addr;
    logic [VALUE_BITS-1:0] rd_a_data, rd_b_data;
    logic                  ld;
    logic [AW-1:0]         cur_idx;

    // clamp sizes to MAX_ELEMS
    function automatic logic [CW-1:0] clamp(input logic [SIZE_BITS-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return (w > 32'(MAX_ELEMS)) ? CW'(MAX_ELEMS) : CW'(w);
    endfunction

    assign na = size_a_reg;
    assign nb = size_b_reg;
    assign busy = (state_reg != S_IDLE);
    // a pending item wins over a register write in the same cycle
    assign cfg_ready = !busy && !start;
    assign ld = start && !busy && (op_t'(op) == OP_LOAD_A || op_t'(op) == OP_LOAD_B);
    assign cur_idx = chosen_reg[pos_reg[AW-1:0]];
    assign rd_a_addr = pos_reg[AW-1:0];
    assign rd_b_addr = cur_idx;

    ime_elem_store #(.MAX_ELEMS(MAX_ELEMS), .VALUE_BITS(VALUE_BITS), .AW(AW)) u_store (
        .clk(clk),
        .wr_a(ld && op_t'(op) == OP_LOAD_A && 32'(slot) < MAX_ELEMS),
        .wr_b(ld && op_t'(op) == OP_LOAD_B && 32'(slot) < MAX_ELEMS),
        .wr_addr(AW'(slot)),
        .wr_data(value),
        .rd_a_addr(rd_a_addr),
        .rd_b_addr(rd_b_addr),
        .rd_a_data(rd_a_data),
        .rd_b_data(rd_b_data)
    );

    // output stage: the memory read is registered and lands in the cycle after the address
    assign strobe   = emit_v_reg || (state_reg == S_DONE);
    assign a_value  = emit_v_reg ? rd_a_data : '0;
    assign b_value  = emit_v_reg ? rd_b_data : '0;
    assign last     = emit_v_reg ? emit_last_reg : (state_reg == S_DONE);
    assign done_res = !emit_v_reg && (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_a_reg    <= CW'(1);
            size_b_reg    <= CW'(1);
            used_reg      <= '0;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
            pos_reg       <= '0;
            cand_reg      <= '0;
            emit_v_reg    <= 1'b0;
            emit_last_reg <= 1'b0;
            for (int i = 0; i < MAX_ELEMS; i++)
            begin
                chosen_reg[i] <= '0;
            end
        end
        else
        begin
            emit_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        if (cfg_index == REG_SIZE_A) size_a_reg <= clamp(cfg_data);
                        else size_b_reg <= clamp(cfg_data);
                        used_reg <= '0;
                        started_reg <= 1'b0;
                        exhausted_reg <= 1'b0;
                    end
                    else if (ld)
                    begin
                        used_reg <= '0;
                        started_reg <= 1'b0;
                        exhausted_reg <= 1'b0;
                    end
                    else if (start && op_t'(op) == OP_NEXT)
                    begin
                        if (exhausted_reg || na == '0 || na > nb)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (!started_reg)
                        begin
                            used_reg <= '0;
                            pos_reg  <= '0;
                            cand_reg <= '0;
                            started_reg <= 1'b1;
                            state_reg <= S_FILL;
                        end
                        else
                        begin
                            pos_reg <= na;
                            state_reg <= S_BACK;
                        end
                    end
                end
                S_BACK:
                begin
                    // step back one position, release its index
                    if (pos_reg == '0)
                    begin
                        exhausted_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pos_reg  <= pos_reg - CW'(1);
                        used_reg[chosen_reg[AW'(pos_reg - CW'(1))]] <= 1'b0;
                        cand_reg <= CW'(chosen_reg[AW'(pos_reg - CW'(1))]) + CW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // look for a free index above the released one
                    if (cand_reg >= nb)
                    begin
                        state_reg <= S_BACK;
                    end
                    else if (!used_reg[cand_reg[AW-1:0]])
                    begin
                        chosen_reg[pos_reg[AW-1:0]] <= cand_reg[AW-1:0];
                        used_reg[cand_reg[AW-1:0]] <= 1'b1;
                        pos_reg  <= pos_reg + CW'(1);
                        cand_reg <= '0;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        cand_reg <= cand_reg + CW'(1);
                    end
                end
                S_FILL:
                begin
                    // smallest free index into each remaining position
                    if (pos_reg >= na)
                    begin
                        pos_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (!used_reg[cand_reg[AW-1:0]])
                    begin
                        chosen_reg[pos_reg[AW-1:0]] <= cand_reg[AW-1:0];
                        used_reg[cand_reg[AW-1:0]] <= 1'b1;
                        pos_reg  <= pos_reg + CW'(1);
                        cand_reg <= '0;
                    end
                    else
                    begin
                        cand_reg <= cand_reg + CW'(1);
                    end
                end
                S_EMIT:
                begin
                    emit_v_reg    <= 1'b1;
                    emit_last_reg <= (pos_reg + CW'(1) == na);
                    if (pos_reg + CW'(1) == na)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + CW'(1);
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `IME_ASSERT_IMPL(a_strobe_excl, clk, rst_n, emit_v_reg, state_reg != S_DONE, "pair and done overlap")
    `IME_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, !busy, "cfg while busy")
    `IME_ASSERT_NEXT(a_done_idle, clk, rst_n, state_reg == S_DONE, state_reg == S_IDLE, "done not single")
    `IME_ASSERT_IMPL(a_fill_bound, clk, rst_n, state_reg == S_FILL && pos_reg < na, cand_reg < nb, "fill ran out of indices")
endmodule

// File: tb/injective_mapping_enumerator_tb.sv
`timescale 1ns / 100ps

module injective_mapping_enumerator_tb;
    import ime_pkg::*;

    // one pair of a mapping, or a done marker
    typedef struct {
        logic [31:0] a_val;
        logic [31:0] b_val;
        logic        last_pair;
        logic        done_flag;
    } pair_t;

    // Predicts the pairs or done result of each accepted next request and checks them in order.
    class mapping_scoreboard;
        logic [31:0] dom_vals[16];
        logic [31:0] cod_vals[16];
        int unsigned pick[16];
        logic [15:0] used;
        bit          walking;
        bit          used_up;
        int unsigned reg_a = 1;
        int unsigned reg_b = 1;
        pair_t       pending[$];
        int          mismatches;
        int          pairs_seen;
        int          dones_seen;

        function void restart_walk();
            foreach (pick[i]) pick[i] = 0;
            used    = '0;
            walking = 0;
            used_up = 0;
        endfunction

        function void write_size(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] d);
            if (idx == REG_SIZE_A) reg_a = d;
            else                   reg_b = d;
            restart_walk();
        endfunction

        function int unsigned free_from(int unsigned lo, int unsigned nb);
            for (int unsigned c = lo; c < nb; c++)
                if (!used[c]) return c;
            return nb;
        endfunction

        function void fill(int unsigned pos, int unsigned na, int unsigned nb);
            int unsigned c;
            for (int unsigned p = pos; p < na; p++)
            begin
                c = free_from(0, nb);
                pick[p] = c;
                used[c] = 1'b1;
            end
        endfunction

        // step to the next k-permutation; 0 when none is left
        function bit advance(int unsigned na, int unsigned nb);
            int unsigned pos;
            int unsigned c;
            pos = na;
            while (pos > 0)
            begin
                pos--;
                used[pick[pos]] = 1'b0;
                c = free_from(pick[pos] + 1, nb);
                if (c < nb)
                begin
                    pick[pos] = c;
                    used[c]   = 1'b1;
                    fill(pos + 1, na, nb);
                    return 1;
                end
            end
            return 0;
        endfunction

        function void push_done();
            pair_t e;
            e.a_val = '0; e.b_val = '0; e.last_pair = 1'b1; e.done_flag = 1'b1;
            pending.push_back(e);
        endfunction

        function void note_item(op_t o, logic [SLOT_BITS-1:0] s, logic [31:0] v);
            int unsigned na;
            int unsigned nb;
            pair_t       e;
            na = (reg_a > 16) ? 16 : reg_a;
            nb = (reg_b > 16) ? 16 : reg_b;
            case (o)
                OP_LOAD_A: begin dom_vals[s] = v; restart_walk(); end
                OP_LOAD_B: begin cod_vals[s] = v; restart_walk(); end
                OP_NEXT:
                begin
                    if (used_up || na == 0 || na > nb)
                    begin
                        push_done();
                        return;
                    end
                    if (!walking)
                    begin
                        used = '0;
                        fill(0, na, nb);
                        walking = 1;
                    end
                    else if (!advance(na, nb))
                    begin
                        used_up = 1;
                        push_done();
                        return;
                    end
                    for (int unsigned p = 0; p < na; p++)
                    begin
                        e.a_val     = dom_vals[p];
                        e.b_val     = cod_vals[pick[p]];
                        e.last_pair = (p + 1 == na);
                        e.done_flag = 1'b0;
                        pending.push_back(e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [31:0] av, logic [31:0] bv, logic l, logic d);
            pair_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result a=%h b=%h last=%b done=%b", av, bv, l, d);
                return;
            end
            e = pending.pop_front();
            if (d) dones_seen++;
            else   pairs_seen++;
            if (av !== e.a_val || bv !== e.b_val || l !== e.last_pair || d !== e.done_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp a=%h b=%h last=%b done=%b, got a=%h b=%h last=%b done=%b",
                             e.a_val, e.b_val, e.last_pair, e.done_flag, av, bv, l, d);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_BITS-1:0]      op;
    logic [SLOT_BITS-1:0]    slot;
    logic signed [31:0]      value;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SIZE_BITS-1:0]    cfg_data;
    logic                    strobe;
    logic signed [31:0]      a_value;
    logic signed [31:0]      b_value;
    logic                    last;
    logic                    done_res;

    mapping_scoreboard sb;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned next_sent;
    int unsigned load_sent;
    int unsigned writes_done;
    int unsigned sa_list[12] = '{1, 2, 3, 1, 16, 0, 5, 31, 20, 2, 4, 3};
    int unsigned sb_list[12] = '{1, 3, 3, 16, 16, 5, 2, 31, 3, 31, 6, 4};

    injective_mapping_enumerator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .slot      (slot),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .a_value   (a_value),
        .b_value   (b_value),
        .last      (last),
        .done_res  (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Results cannot be held off: every strobe is checked at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(a_value, b_value, last, done_res);
    end

    // Guards the whole run against a hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one item and hold it until accepted; start stays high afterward
    // so back-to-back items need no drop.
    task automatic send_item(op_t o, logic [SLOT_BITS-1:0] s, logic [31:0] v);
        start <= 1'b1;
        op    <= o;
        slot  <= s;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(o, s, v);
        items_sent++;
        if (o == OP_NEXT) next_sent++;
        if (o == OP_LOAD_A || o == OP_LOAD_B) load_sent++;
    endtask

    task automatic pause(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Wait until every predicted pair has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] d);
        drain();
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_size(idx, d);
        writes_done++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned phase;
        int unsigned n;
        int unsigned burst;
        int unsigned r;

        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_NONE;
        slot        = '0;
        value       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_SIZE_A;
        cfg_data    = '0;
        cycle_count = 0;
        items_sent  = 0;
        next_sent   = 0;
        load_sent   = 0;
        writes_done = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sizes at reset (1,1), extremes of values, exhaustion,
        // unused op, empty domain, domain larger than codomain.
        send_item(OP_LOAD_A, 4'd0, 32'h8000_0000);
        send_item(OP_LOAD_B, 4'd0, 32'h7fff_ffff);
        send_item(OP_NEXT, 4'd0, 32'h0);
        send_item(OP_NEXT, 4'd15, 32'hffff_ffff);   // exhausted: done
        send_item(OP_NEXT, 4'd0, 32'h0);            // still done
        send_item(OP_NONE, 4'd15, 32'hffff_ffff);
        send_item(OP_LOAD_B, 4'd15, 32'h0);         // load restarts the walk
        send_item(OP_NEXT, 4'd0, 32'h0);
        write_reg(REG_SIZE_A, 5'd0);
        send_item(OP_NEXT, 4'd0, 32'h0);            // empty domain: done
        write_reg(REG_SIZE_A, 5'd2);
        send_item(OP_NEXT, 4'd0, 32'h0);            // 2 into 1: done
        pause(3);

        // Fill every slot of both stores so no read ever hits an unwritten entry.
        for (int unsigned s = 0; s < 16; s++)
        begin
            send_item(OP_LOAD_A, s[3:0], pick_value());
            send_item(OP_LOAD_B, s[3:0], pick_value());
        end

        // Random phases: one size setting each, then mostly next requests in
        // bursts, with loads and unused ops mixed in.
        phase = 0;
        while (items_sent < 410)
        begin
            if (phase < 12)
            begin
                write_reg(REG_SIZE_A, SIZE_BITS'(sa_list[phase]));
                write_reg(REG_SIZE_B, SIZE_BITS'(sb_list[phase]));
            end
            else
            begin
                write_reg(REG_SIZE_B, SIZE_BITS'($urandom_range(1, 6)));
                write_reg(REG_SIZE_A, SIZE_BITS'($urandom_range(1, 4)));
            end
            n     = (sa_list[phase % 12] >= 16 && phase < 12) ? 6 : $urandom_range(15, 40);
            burst = $urandom_range(1, 8);
            for (int unsigned k = 0; k < n; k++)
            begin
                r = $urandom_range(99);
                if (r < 84)
                    send_item(OP_NEXT, SLOT_BITS'($urandom), $urandom);
                else if (r < 89)
                    send_item(OP_LOAD_A, SLOT_BITS'($urandom), pick_value());
                else if (r < 94)
                    send_item(OP_LOAD_B, SLOT_BITS'($urandom), pick_value());
                else
                    send_item(OP_NONE, SLOT_BITS'($urandom), $urandom);
                if (phase == 2 && k == n / 2)
                    drain();                        // sender holds until all pairs are in
                burst--;
                if (burst == 0)
                begin
                    if ($urandom_range(3) != 0)
                        pause($urandom_range(1, 12));
                    burst = $urandom_range(1, 10);
                end
            end
            phase++;
        end

        drain();
        repeat (40) @(posedge clk);
        r = sb.pending.size();
        sb.mismatches += r;
        $display("%0d items (%0d next, %0d loads), %0d size writes over %0d settings",
                 items_sent, next_sent, load_sent, writes_done, phase);
        $display("%0d pairs and %0d done results checked, %0d mismatches",
                 sb.pairs_seen, sb.dones_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
